// ----- sv/f2t_pkg.sv -----
// ----------------------------------------------------------------------------
// f2t_pkg
// Types, character codes and digit tables for the float-to-text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package f2t_pkg;

	localparam int unsigned FLOAT_W  = 32;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned INT_W    = 16;
	localparam int unsigned BCD_DIGS = 5;
	localparam int unsigned BCD_W    = 4 * BCD_DIGS;
	localparam int unsigned TXT_MAX  = 7;

	localparam logic [7:0] EXP_BIAS = 8'd127;
	localparam logic signed [7:0] EXP_MAX = 8'sd18;
	localparam logic signed [7:0] EXP_MIN = -8'sd3;
	localparam logic [4:0] FRAC_SHIFT_BASE = 5'd20;
	localparam logic [23:0] HIDDEN_BIT = 24'h800000;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2e;

	localparam logic [23:0] INF_TXT = "Inf";

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} f2t_state_t;

	typedef enum logic [1:0] {
		MODE_NUM,
		MODE_INF,
		MODE_ZERO
	} txt_mode_t;

	function automatic logic [CHAR_W-1:0] pick3(input logic [23:0] s, input logic [1:0] idx);
		logic [CHAR_W-1:0] c;
		c = s[23:16];
		unique case (idx)
			2'd0: c = s[23:16];
			2'd1: c = s[15:8];
			2'd2: c = s[7:0];
			default: c = s[7:0];
		endcase
		return c;
	endfunction

	// eighths as three decimal places
	function automatic logic [CHAR_W-1:0] frac_char(input logic [2:0] sel, input logic [1:0] idx);
		logic [23:0] s;
		s = "000";
		unique case (sel)
			3'd0: s = "000";
			3'd1: s = "125";
			3'd2: s = "250";
			3'd3: s = "375";
			3'd4: s = "500";
			3'd5: s = "625";
			3'd6: s = "750";
			3'd7: s = "875";
			default: s = "000";
		endcase
		return pick3(s, idx);
	endfunction

endpackage

`default_nettype wire

// ----- sv/float_to_decimal_text.sv -----
// "Inf" and "0" go from accept straight to the emit state; a number first runs the conversion loop.
// A new value is taken only when idle, after the previous text's last word; texts are 1..7 words long.
// The conversion loop is 16 steps of shift-add-3 binary-to-BCD on one shared digit-correct unit.
// busy stays high from accept until the last word is registered out.
// The receiver cannot stall: each word is shown for exactly one cycle with text_valid.
// Reset (arst_n low, asynchronous) returns to idle with no word pending.
// ----------------------------------------------------------------------------
// float_to_decimal_text
// Converts IEEE single bits to decimal text at eighth resolution, one
// ASCII word per strobe, last word flagged.
// ----------------------------------------------------------------------------
`default_nettype none

module float_to_decimal_text (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [f2t_pkg::FLOAT_W-1:0]   float_bits,
	output logic                               text_valid,
	output logic [f2t_pkg::CHAR_W-1:0]         text_char,
	output logic                               last_char
);
	import f2t_pkg::*;

	f2t_state_t state_q, state_d;
	txt_mode_t  mode_q, mode_in;

	logic              neg_q;
	logic [2:0]        fsel_q;
	logic [INT_W-1:0]  bin_q;
	logic [BCD_W-1:0]  bcd_q, bcd_adj;
	logic [3:0]        step_q;
	logic [2:0]        cnt_q;

	logic [7:0]        e_unb;
	logic [4:0]        fshift;
	logic [23:0]       mant;
	logic [23:0]       mant_sh;

	logic [2:0]        nd, base, len, len_m1, p, dig_idx;
	logic [1:0]        frac_idx;
	logic [3:0]        nib;
	logic              has_pt;
	logic [CHAR_W-1:0] ch_sel, ch_d;
	logic              last_d, emit, step_en, accept;

	// decode and align on accept
	assign e_unb   = float_bits[30:23] - EXP_BIAS;
	assign fshift  = FRAC_SHIFT_BASE - e_unb[4:0];
	assign mant    = {1'b0, float_bits[22:0]} | HIDDEN_BIT;
	assign mant_sh = mant >> fshift;

	always_comb begin
		if ($signed(e_unb) > EXP_MAX) begin
			mode_in = MODE_INF;
		end else if ($signed(e_unb) < EXP_MIN) begin
			mode_in = MODE_ZERO;
		end else begin
			mode_in = MODE_NUM;
		end
	end

	// shared add-3 digit correction
	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < BCD_DIGS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
	end

	// text layout
	always_comb begin
		if (bcd_q[19:16] != 4'd0) begin
			nd = 3'd5;
		end else if (bcd_q[15:12] != 4'd0) begin
			nd = 3'd4;
		end else if (bcd_q[11:8] != 4'd0) begin
			nd = 3'd3;
		end else if (bcd_q[7:4] != 4'd0) begin
			nd = 3'd2;
		end else begin
			nd = 3'd1;
		end
		base   = nd + {2'd0, neg_q};
		has_pt = (base <= 3'd5);
		if (!has_pt) begin
			len = base;
		end else if (base >= 3'd3) begin
			len = 3'd7;
		end else begin
			len = base + 3'd4;
		end
		unique case (mode_q)
			MODE_INF:  len_m1 = 3'd2;
			MODE_ZERO: len_m1 = 3'd0;
			default:   len_m1 = len - 3'd1;
		endcase
		p        = cnt_q - {2'd0, neg_q};
		dig_idx  = nd - 3'd1 - p;
		frac_idx = 2'(p - nd - 3'd1);
		unique case (dig_idx)
			3'd0: nib = bcd_q[3:0];
			3'd1: nib = bcd_q[7:4];
			3'd2: nib = bcd_q[11:8];
			3'd3: nib = bcd_q[15:12];
			3'd4: nib = bcd_q[19:16];
			default: nib = 4'd0;
		endcase
		priority if (mode_q == MODE_INF) begin
			ch_sel = pick3(INF_TXT, cnt_q[1:0]);
		end else if (mode_q == MODE_ZERO) begin
			ch_sel = CH_ZERO;
		end else if (neg_q && cnt_q == 3'd0) begin
			ch_sel = CH_MINUS;
		end else if (p < nd) begin
			ch_sel = CH_ZERO + {4'd0, nib};
		end else if (p == nd) begin
			ch_sel = CH_POINT;
		end else begin
			ch_sel = frac_char(fsel_q, frac_idx);
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		step_en = 1'b0;
		emit    = 1'b0;
		accept  = 1'b0;
		ch_d    = ch_sel;
		last_d  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					accept  = 1'b1;
					state_d = (mode_in == MODE_NUM) ? ST_CONV : ST_EMIT;
				end
			end
			ST_CONV: begin
				step_en = 1'b1;
				if (step_q == 4'd15) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				emit   = 1'b1;
				last_d = (cnt_q == len_m1);
				if (last_d) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			text_valid <= 1'b0;
			step_q     <= 4'd0;
			cnt_q      <= 3'd0;
		end else begin
			state_q    <= state_d;
			text_valid <= emit;
			if (accept) begin
				step_q <= 4'd0;
				cnt_q  <= 3'd0;
			end else begin
				if (step_en) begin
					step_q <= step_q + 4'd1;
				end
				if (emit) begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_in;
			neg_q  <= float_bits[31];
			fsel_q <= mant_sh[2:0];
			bin_q  <= mant_sh[18:3];
			bcd_q  <= '0;
		end else if (step_en) begin
			{bcd_q, bin_q} <= {bcd_adj[BCD_W-2:0], bin_q, 1'b0};
		end
		if (emit) begin
			text_char <= ch_d;
			last_char <= last_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

`ifndef SYNTH
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised after accept");
	a_valid_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid |-> $past(busy)) else $error("word outside a conversion");
	a_words_contig: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !last_char |=> text_valid) else $error("gap inside text");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && last_char |=> !text_valid) else $error("word after last");
`endif

endmodule

`default_nettype wire

// ----- bench/float_to_decimal_text_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// float_to_decimal_text_test
// Self-checking bench for the float-to-text converter. A short table of
// edge values (zeros, denormals, exponent wrap, Inf, exponent limits,
// 16-bit overflow, missing point, fraction cut-off) is sent first. Several
// hundred random floats follow, biased toward exponents that print a number.
// Every character word is compared with the typed table text or a local formatter.
// ----------------------------------------------------------------------------

module float_to_decimal_text_test;

	import f2t_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RAND_ITEMS  = 306;
	localparam int unsigned DIR_ITEMS   = 24;
	localparam int unsigned TAIL_CYCLES = 30;
	localparam int unsigned MAX_PRINTS  = 30;

	typedef struct packed {
		logic [TXT_MAX-1:0][CHAR_W-1:0] ch;
		logic [3:0]                     len;
	} float_text_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_word_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [FLOAT_W-1:0] float_bits;
	logic               text_valid;
	logic [CHAR_W-1:0]  text_char;
	logic               last_char;

	text_word_t  pending_words[$];
	int unsigned err_count;
	int unsigned cycle_count;
	int unsigned values_sent;
	int unsigned words_checked;
	int unsigned inf_texts;
	int unsigned zero_texts;
	int unsigned num_texts;

	logic [FLOAT_W-1:0] dir_bits [DIR_ITEMS];
	string              dir_text [DIR_ITEMS];

	float_to_decimal_text DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.float_bits (float_bits),
		.text_valid (text_valid),
		.text_char  (text_char),
		.last_char  (last_char)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic note_mismatch(input string msg);
		if (err_count < MAX_PRINTS) begin
			$display("MISMATCH @%0d: %s", cycle_count, msg);
		end
		err_count++;
	endtask

	// eighth-resolution decimal text of one float word
	function automatic float_text_t float_text(input logic [FLOAT_W-1:0] bits);
		float_text_t       t;
		logic signed [7:0] e;
		logic [31:0]       m;
		logic [31:0]       ipart;
		logic [31:0]       eighths;
		logic [4:0][7:0]   dig;
		int                nd;
		int                i;
		t = '0;
		dig = '0;
		e = bits[30:23] - EXP_BIAS;
		m = {8'h00, 1'b1, bits[22:0]};
		if (e > EXP_MAX) begin
			t.ch[0] = "I";
			t.ch[1] = "n";
			t.ch[2] = "f";
			t.len = 3;
			return t;
		end
		if (e < EXP_MIN) begin
			t.ch[0] = CH_ZERO;
			t.len = 1;
			return t;
		end
		if (bits[31]) begin
			t.ch[t.len] = CH_MINUS;
			t.len++;
		end
		ipart = (m >> (23 - int'(e))) & 32'h0000_ffff;
		nd = 0;
		do begin
			dig[nd] = CH_ZERO + 8'(ipart % 10);
			ipart = ipart / 10;
			nd++;
		end while (ipart > 0 && nd < 5);
		for (i = nd - 1; i >= 0; i--) begin
			t.ch[t.len] = dig[i];
			t.len++;
		end
		if (t.len > 5) begin
			return t;
		end
		t.ch[t.len] = CH_POINT;
		t.len++;
		eighths = ((m >> (20 - int'(e))) & 32'h7) * 125;
		dig[2] = CH_ZERO + 8'(eighths / 100);
		dig[1] = CH_ZERO + 8'((eighths / 10) % 10);
		dig[0] = CH_ZERO + 8'(eighths % 10);
		for (i = 2; i >= 0; i--) begin
			if (t.len < TXT_MAX) begin
				t.ch[t.len] = dig[i];
				t.len++;
			end
		end
		return t;
	endfunction

	function automatic float_text_t typed_text(input string s);
		float_text_t t;
		int          i;
		t = '0;
		for (i = 0; i < s.len(); i++) begin
			t.ch[i] = s[i];
		end
		t.len = 4'(s.len());
		return t;
	endfunction

	task automatic queue_text(input float_text_t t);
		text_word_t w;
		int         i;
		for (i = 0; i < t.len; i++) begin
			w.ch = t.ch[i];
			w.last = (i == t.len - 1);
			pending_words.push_back(w);
		end
		if (t.ch[0] == "I") begin
			inf_texts++;
		end else if (t.len == 1) begin
			zero_texts++;
		end else begin
			num_texts++;
		end
	endtask

	// returns at the edge that took the word; start is left high
	task automatic send_float(input logic [FLOAT_W-1:0] bits, input int unsigned gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		float_bits <= bits;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		values_sent++;
	endtask

	function automatic logic [FLOAT_W-1:0] draw_float();
		logic [7:0]  efield;
		logic [22:0] mant;
		logic        sign;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		sign = 1'($urandom_range(0, 1));
		mant = 23'($urandom());
		case (pick)
			7: efield = 8'($urandom_range(146, 255));
			8: efield = 8'($urandom_range(0, 123));
			9: return $urandom();
			default: efield = 8'($urandom_range(124, 145));
		endcase
		return {sign, efield, mant};
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding",
				cycle_count, pending_words.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		text_word_t w;
		if (arst_n && text_valid) begin
			if (pending_words.size() == 0) begin
				note_mismatch($sformatf("stray word %h last %b", text_char, last_char));
			end else begin
				w = pending_words.pop_front();
				if (text_char !== w.ch) begin
					note_mismatch($sformatf("char %h, want %h", text_char, w.ch));
				end
				if (last_char !== w.last) begin
					note_mismatch($sformatf("last %b, want %b on char %h",
						last_char, w.last, w.ch));
				end
				words_checked++;
			end
		end
	end

	initial begin
		int unsigned i;
		int unsigned gap;
		logic [FLOAT_W-1:0] v;

		err_count = 0;
		cycle_count = 0;
		values_sent = 0;
		words_checked = 0;
		inf_texts = 0;
		zero_texts = 0;
		num_texts = 0;
		arst_n = 1'b0;
		start = 1'b0;
		float_bits = '0;

		// empty text means the formatter supplies the expectation
		dir_bits[0]  = 32'h0000_0000; dir_text[0]  = "0";
		dir_bits[1]  = 32'h8000_0000; dir_text[1]  = "0";
		dir_bits[2]  = 32'h0000_0001; dir_text[2]  = "0";
		dir_bits[3]  = 32'hffff_ffff; dir_text[3]  = "0";
		dir_bits[4]  = 32'h7f80_0000; dir_text[4]  = "0";
		dir_bits[5]  = 32'h7fff_ffff; dir_text[5]  = "0";
		dir_bits[6]  = 32'h7f7f_ffff; dir_text[6]  = "Inf";
		dir_bits[7]  = 32'hc900_0000; dir_text[7]  = "Inf";
		dir_bits[8]  = 32'h3f80_0000; dir_text[8]  = "1.000";
		dir_bits[9]  = 32'hbf80_0000; dir_text[9]  = "-1.000";
		dir_bits[10] = 32'h3e00_0000; dir_text[10] = "0.125";
		dir_bits[11] = 32'hbe00_0000; dir_text[11] = "-0.125";
		dir_bits[12] = 32'h3dff_ffff; dir_text[12] = "0";
		dir_bits[13] = 32'h3e7f_ffff; dir_text[13] = "";
		dir_bits[14] = 32'h48ff_ffff; dir_text[14] = "";
		dir_bits[15] = 32'hc8ff_ffff; dir_text[15] = "";
		dir_bits[16] = 32'h4780_0000; dir_text[16] = "";
		dir_bits[17] = 32'hc780_0000; dir_text[17] = "";
		dir_bits[18] = 32'h4880_0000; dir_text[18] = "";
		dir_bits[19] = 32'h447a_2000; dir_text[19] = "";
		dir_bits[20] = 32'h4119_0000; dir_text[20] = "";
		dir_bits[21] = 32'h42c8_0000; dir_text[21] = "";
		dir_bits[22] = 32'h3f7f_ffff; dir_text[22] = "";
		dir_bits[23] = 32'hc47a_2000; dir_text[23] = "";

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < DIR_ITEMS; i++) begin
			send_float(dir_bits[i], $urandom_range(0, 12));
			if (dir_text[i].len() > 0) begin
				queue_text(typed_text(dir_text[i]));
			end else begin
				queue_text(float_text(dir_bits[i]));
			end
		end

		for (i = 0; i < RAND_ITEMS; i++) begin
			if (i == 120) begin
				start <= 1'b0;
				while (pending_words.size() != 0) begin
					@(posedge clk);
				end
			end
			// back-to-back stretch
			gap = (i >= 200 && i < 260) ? 0 : $urandom_range(0, 12);
			v = draw_float();
			send_float(v, gap);
			queue_text(float_text(v));
		end

		start <= 1'b0;
		while (pending_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d floats sent (%0d table, %0d random), %0d characters checked",
			values_sent, DIR_ITEMS, RAND_ITEMS, words_checked);
		$display("texts: %0d Inf, %0d zero, %0d numeric; %0d mismatches",
			inf_texts, zero_texts, num_texts, err_count);
		if (err_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
